FILE: hw/rtl/lzf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZF frame decompressor package
// Shared types and fixed constants for the parser, the command queue and the
// copy engine.
// ----------------------------------------------------------------------------
package lzf_pkg;

  localparam int unsigned LEN_W   = 31;
  localparam int unsigned OFF_W   = 14;
  localparam int unsigned RUN_W   = 9;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_HEADER,
    PH_STORED,
    PH_CTRL,
    PH_LITERAL,
    PH_REFLEN,
    PH_REFOFF,
    PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_BYTE,
    CMD_COPY
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_END
  } back_state_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    logic [OFF_W-1:0]  offset;
    logic [RUN_W-1:0]  len;
    logic              is_end;
    logic              ok;
    logic [LEN_W-1:0]  dlen;
  } cmd_t;

endpackage

FILE: hw/rtl/lzf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZF frame parser
// Decodes the length header and the control stream, checks literal runs and
// references against the frame length and issues byte, copy and close commands.
// ----------------------------------------------------------------------------
module lzf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          push_o,
  output lzf_pkg::cmd_t cmd_o
);

  lzf_pkg::phase_e                phase_q, phase_d;
  logic [lzf_pkg::LEN_W-1:0]      exp_q, exp_d;
  logic [lzf_pkg::LEN_W-1:0]      prod_q, prod_d;
  logic [2:0]                     hdr_q, hdr_d;
  logic [lzf_pkg::RUN_W-1:0]      run_q, run_d;
  logic [4:0]                     offh_q, offh_d;
  logic                           err_q, err_d;

  logic [lzf_pkg::LEN_W:0]        lit_sum, ref_sum;
  logic [lzf_pkg::OFF_W-1:0]      ref_off;
  logic [lzf_pkg::RUN_W-1:0]      ref_total;
  logic                           lit_ovr, ref_ovr, ref_early;
  logic                           ok;

  assign lit_sum   = {1'b0, prod_q} + (lzf_pkg::LEN_W+1)'(in_byte_i[4:0]) + 1'b1;
  assign ref_total = run_q + lzf_pkg::RUN_W'(2);
  assign ref_sum   = {1'b0, prod_q} + (lzf_pkg::LEN_W+1)'(ref_total);
  assign ref_off   = {1'b0, offh_q, in_byte_i} + lzf_pkg::OFF_W'(1);
  assign lit_ovr   = lit_sum > {1'b0, exp_q};
  assign ref_ovr   = ref_sum > {1'b0, exp_q};
  assign ref_early = lzf_pkg::LEN_W'(ref_off) > prod_q;

  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    prod_d  = prod_q;
    hdr_d   = hdr_q;
    run_d   = run_q;
    offh_d  = offh_q;
    err_d   = err_q;
    unique case (phase_q)
      lzf_pkg::PH_FIRST: begin
        if (in_byte_i == 8'h00) begin
          phase_d = lzf_pkg::PH_STORED;
        end else if (!in_byte_i[7]) begin
          exp_d   = lzf_pkg::LEN_W'(in_byte_i);
          phase_d = lzf_pkg::PH_CTRL;
        end else begin
          phase_d = lzf_pkg::PH_HEADER;
          if ((in_byte_i & 8'he0) == 8'hc0) begin
            exp_d = lzf_pkg::LEN_W'(in_byte_i & 8'h1f);
            hdr_d = 3'd1;
          end else if ((in_byte_i & 8'hf0) == 8'he0) begin
            exp_d = lzf_pkg::LEN_W'(in_byte_i & 8'h0f);
            hdr_d = 3'd2;
          end else if ((in_byte_i & 8'hf8) == 8'hf0) begin
            exp_d = lzf_pkg::LEN_W'(in_byte_i & 8'h07);
            hdr_d = 3'd3;
          end else if ((in_byte_i & 8'hfc) == 8'hf8) begin
            exp_d = lzf_pkg::LEN_W'(in_byte_i & 8'h03);
            hdr_d = 3'd4;
          end else begin
            exp_d = lzf_pkg::LEN_W'(in_byte_i & 8'h01);
            hdr_d = 3'd5;
          end
        end
      end
      lzf_pkg::PH_HEADER: begin
        exp_d = {exp_q[lzf_pkg::LEN_W-7:0], in_byte_i[5:0]};
        hdr_d = hdr_q - 3'd1;
        if (hdr_q == 3'd1) phase_d = lzf_pkg::PH_CTRL;
      end
      lzf_pkg::PH_STORED: begin
        prod_d = prod_q + 1'b1;
      end
      lzf_pkg::PH_CTRL: begin
        if (in_byte_i < 8'h20) begin
          if (lit_ovr) begin
            err_d   = 1'b1;
            phase_d = lzf_pkg::PH_DRAIN;
          end else begin
            run_d   = lzf_pkg::RUN_W'(in_byte_i[4:0]) + 1'b1;
            phase_d = lzf_pkg::PH_LITERAL;
          end
        end else begin
          run_d   = lzf_pkg::RUN_W'(in_byte_i[7:5]);
          offh_d  = in_byte_i[4:0];
          phase_d = (in_byte_i[7:5] == 3'd7) ? lzf_pkg::PH_REFLEN : lzf_pkg::PH_REFOFF;
        end
      end
      lzf_pkg::PH_LITERAL: begin
        prod_d = prod_q + 1'b1;
        run_d  = run_q - 1'b1;
        if (run_q == lzf_pkg::RUN_W'(1)) phase_d = lzf_pkg::PH_CTRL;
      end
      lzf_pkg::PH_REFLEN: begin
        run_d   = run_q + lzf_pkg::RUN_W'(in_byte_i);
        phase_d = lzf_pkg::PH_REFOFF;
      end
      lzf_pkg::PH_REFOFF: begin
        if (ref_ovr || ref_early) begin
          err_d   = 1'b1;
          phase_d = lzf_pkg::PH_DRAIN;
        end else begin
          prod_d  = ref_sum[lzf_pkg::LEN_W-1:0];
          run_d   = '0;
          phase_d = lzf_pkg::PH_CTRL;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = lzf_pkg::CMD_NONE;
    cmd_o.data   = in_byte_i;
    cmd_o.offset = ref_off;
    cmd_o.len    = ref_total;
    unique case (phase_q)
      lzf_pkg::PH_STORED, lzf_pkg::PH_LITERAL: cmd_o.kind = lzf_pkg::CMD_BYTE;
      lzf_pkg::PH_REFOFF: begin
        if (!ref_ovr && !ref_early) cmd_o.kind = lzf_pkg::CMD_COPY;
      end
      default: ;
    endcase
    if (err_d) begin
      ok = 1'b0;
    end else if (phase_d == lzf_pkg::PH_STORED) begin
      ok = 1'b1;
    end else if (phase_d == lzf_pkg::PH_CTRL) begin
      ok = (prod_d == exp_d);
    end else begin
      ok = 1'b0;
    end
    cmd_o.is_end = in_last_i;
    cmd_o.ok     = ok;
    cmd_o.dlen   = prod_d;
    push_o       = accept_i && (in_last_i || (cmd_o.kind != lzf_pkg::CMD_NONE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lzf_pkg::PH_FIRST;
      exp_q   <= '0;
      prod_q  <= '0;
      hdr_q   <= '0;
      run_q   <= '0;
      offh_q  <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      if (in_last_i) begin
        phase_q <= lzf_pkg::PH_FIRST;
        exp_q   <= '0;
        prod_q  <= '0;
        hdr_q   <= '0;
        run_q   <= '0;
        offh_q  <= '0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        exp_q   <= exp_d;
        prod_q  <= prod_d;
        hdr_q   <= hdr_d;
        run_q   <= run_d;
        offh_q  <= offh_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

FILE: hw/rtl/lzf_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZF command queue
// Short register queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lzf_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output lzf_pkg::cmd_t cmd_o
);

  lzf_pkg::cmd_t                 mem_q [lzf_pkg::QDEPTH];
  logic [lzf_pkg::QPTR_W-1:0]    wr_q, rd_q;
  logic [lzf_pkg::QCNT_W-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == lzf_pkg::QCNT_W'(lzf_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/lzf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZF copy engine
// Writes decoded bytes to the history memory, sends each stored or literal byte
// as its own word and expands back references one byte at a time into packed words.
// ----------------------------------------------------------------------------
module lzf_back #(
  parameter int unsigned HISTORY_DEPTH = 8192,
  parameter int unsigned WORD_BYTES    = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  lzf_pkg::cmd_t             cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [63:0]               out_word_o,
  output logic [3:0]                out_count_o,
  output logic                      frame_end_o,
  output logic                      frame_ok_o,
  output logic [lzf_pkg::LEN_W-1:0] decoded_length_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(WORD_BYTES + 1);

  logic [7:0]                  hist_mem [HISTORY_DEPTH];
  logic [7:0]                  rdata_q;

  lzf_pkg::back_state_e        state_q, state_d;
  logic [AW-1:0]               wptr_q, rptr_q;
  logic [lzf_pkg::RUN_W-1:0]   left_q;
  logic [63:0]                 word_q, word_ins;
  logic [CW-1:0]               cnt_q, cnt_inc;
  logic                        end_q, ok_q;
  logic [lzf_pkg::LEN_W-1:0]   dlen_q;

  logic                        out_free, mem_we, mem_re, emit;
  logic [7:0]                  wbyte;
  logic [63:0]                 ld_word;
  logic [3:0]                  ld_count;
  logic                        ld_data, ld_end;

  assign out_free = !out_valid_o || !out_stall_i;
  assign cnt_inc  = cnt_q + 1'b1;
  assign emit     = (cnt_inc == CW'(WORD_BYTES)) || (left_q == lzf_pkg::RUN_W'(1));

  always_comb begin
    word_ins = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      word_ins[8*i +: 8] = (cnt_q == CW'(i)) ? rdata_q : word_q[8*i +: 8];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzf_pkg::BK_IDLE: begin
        if (!empty_i) begin
          priority case (cmd_i.kind)
            lzf_pkg::CMD_BYTE: begin
              if (out_free && cmd_i.is_end) state_d = lzf_pkg::BK_END;
            end
            lzf_pkg::CMD_COPY: state_d = lzf_pkg::BK_READ;
            default: begin
              if (cmd_i.is_end) state_d = lzf_pkg::BK_END;
            end
          endcase
        end
      end
      lzf_pkg::BK_READ: state_d = lzf_pkg::BK_WRITE;
      lzf_pkg::BK_WRITE: begin
        if (!emit || out_free) begin
          if (left_q == lzf_pkg::RUN_W'(1)) begin
            state_d = end_q ? lzf_pkg::BK_END : lzf_pkg::BK_IDLE;
          end else begin
            state_d = lzf_pkg::BK_READ;
          end
        end
      end
      lzf_pkg::BK_END: begin
        if (out_free) state_d = lzf_pkg::BK_IDLE;
      end
      default: state_d = lzf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = (state_q == lzf_pkg::BK_READ);
    wbyte    = rdata_q;
    ld_data  = 1'b0;
    ld_end   = 1'b0;
    ld_word  = word_ins;
    ld_count = 4'(cnt_inc);
    unique case (state_q)
      lzf_pkg::BK_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.kind == lzf_pkg::CMD_BYTE) begin
            pop_o    = out_free;
            mem_we   = out_free;
            ld_data  = out_free;
            wbyte    = cmd_i.data;
            ld_word  = {56'd0, cmd_i.data};
            ld_count = 4'd1;
          end else begin
            pop_o = 1'b1;
          end
        end
      end
      lzf_pkg::BK_WRITE: begin
        mem_we  = !emit || out_free;
        ld_data = emit && out_free;
      end
      lzf_pkg::BK_END: ld_end = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[wptr_q] <= wbyte;
    if (mem_re) rdata_q <= hist_mem[rptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzf_pkg::BK_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      end_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) wptr_q <= wptr_q + 1'b1;
      if (state_q == lzf_pkg::BK_IDLE && pop_o) begin
        end_q  <= cmd_i.is_end;
        rptr_q <= wptr_q - AW'(cmd_i.offset);
        left_q <= cmd_i.len;
        cnt_q  <= '0;
      end
      if (mem_re) rptr_q <= rptr_q + 1'b1;
      if (state_q == lzf_pkg::BK_WRITE && mem_we) begin
        left_q <= left_q - 1'b1;
        cnt_q  <= emit ? '0 : cnt_inc;
      end
      if (ld_end) wptr_q <= '0;
      if (ld_data || ld_end) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lzf_pkg::BK_IDLE && pop_o) begin
      ok_q   <= cmd_i.ok;
      dlen_q <= cmd_i.dlen;
      word_q <= '0;
    end
    if (state_q == lzf_pkg::BK_WRITE && mem_we) word_q <= emit ? '0 : word_ins;
    if (ld_data) begin
      out_word_o       <= ld_word;
      out_count_o      <= ld_count;
      frame_end_o      <= 1'b0;
      frame_ok_o       <= 1'b0;
      decoded_length_o <= '0;
    end else if (ld_end) begin
      out_word_o       <= '0;
      out_count_o      <= '0;
      frame_end_o      <= 1'b1;
      frame_ok_o       <= ok_q;
      decoded_length_o <= dlen_q;
    end
  end

endmodule

FILE: hw/rtl/lzf_frame_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZF frame decompressor
// Streaming decoder for length-prefixed LZF frames with an 8 KiB history.
// ----------------------------------------------------------------------------
// Input channel: one compressed byte per transaction, in_last_i on the final
// byte of a frame. Output channel: packed words of up to WORD_BYTES bytes,
// first byte in the low bits; a frame closes with one extra transaction with
// frame_end_o set, frame_ok_o and decoded_length_o.
// The parser handles one byte per cycle while the queue is not full and feeds a 4-entry command queue.
// With the copy engine idle and the output register free, a stored or literal
// byte goes from the command queue straight into the output register.
// A back reference holds the copy engine while it takes the command and then
// does a read and a write per byte on the history memory.
// The close transaction comes after the last data word of the frame, if any.
// Reset clears the parser, the queue, the copy engine and the output valid flag;
// the history memory is not cleared and needs no clearing pass.
// A stalled receiver holds the output register; the copy engine then waits
// and, once the queue is full, in_stall_o rises.
// ----------------------------------------------------------------------------
module lzf_frame_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 8192,
  parameter int unsigned WORD_BYTES    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_count_o,
  output logic        frame_end_o,
  output logic        frame_ok_o,
  output logic [30:0] decoded_length_o
);

  logic          accept, push, pop, full, empty;
  lzf_pkg::cmd_t push_cmd, pop_cmd;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  lzf_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i  (accept),
    .in_byte_i,
    .in_last_i,
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  lzf_cmd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .cmd_o   (pop_cmd)
  );

  lzf_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .WORD_BYTES    (WORD_BYTES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .empty_i          (empty),
    .cmd_i            (pop_cmd),
    .pop_o            (pop),
    .out_valid_o,
    .out_stall_i,
    .out_word_o,
    .out_count_o,
    .frame_end_o,
    .frame_ok_o,
    .decoded_length_o
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZF frame decompressor testbench
// Builds stored and LZF frames, both well formed and broken, drives them byte
// by byte with random gaps and receiver stalls, and checks every output
// transaction against a predicted word stream kept in a queue.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WB = 8;
  localparam int unsigned HDEPTH = 8192;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        fend;
    logic        fok;
    logic [30:0] dlen;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        in_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_word_o;
  logic [3:0]  out_count_o;
  logic        frame_end_o;
  logic        frame_ok_o;
  logic [30:0] decoded_length_o;

  in_item_t pending_bytes[$];
  word_t    expected_words[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_off = 0;
  int       sent_total = 0;
  bit       sender_pause = 1'b0;

  // predictor state
  logic [7:0]       hist[HDEPTH];
  lzf_pkg::phase_e  ph;
  logic [30:0]      exp_len;
  logic [30:0]      prod;
  logic [2:0]       hdr_left;
  logic [8:0]       run_left;
  logic [4:0]       off_hi;
  logic             err;
  logic [7:0]       step_bytes[$];

  lzf_frame_decompressor i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 40);
  endfunction

  task automatic clear_frame();
    ph = lzf_pkg::PH_FIRST; exp_len = '0; prod = '0; hdr_left = '0;
    run_left = '0; off_hi = '0; err = 1'b0;
  endtask

  task automatic emit(input logic [7:0] v);
    hist[prod % HDEPTH] = v;
    prod = prod + 31'd1;
    step_bytes.push_back(v);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    int unsigned off, total, n, cnt;
    word_t w;
    logic ok;
    step_bytes.delete();
    case (ph)
      lzf_pkg::PH_FIRST: begin
        if (b == 8'h00) ph = lzf_pkg::PH_STORED;
        else if (b < 8'h80) begin
          exp_len = 31'(b); ph = lzf_pkg::PH_CTRL;
        end else begin
          if ((b & 8'he0) == 8'hc0) begin exp_len = 31'(b & 8'h1f); hdr_left = 3'd1; end
          else if ((b & 8'hf0) == 8'he0) begin exp_len = 31'(b & 8'h0f); hdr_left = 3'd2; end
          else if ((b & 8'hf8) == 8'hf0) begin exp_len = 31'(b & 8'h07); hdr_left = 3'd3; end
          else if ((b & 8'hfc) == 8'hf8) begin exp_len = 31'(b & 8'h03); hdr_left = 3'd4; end
          else begin exp_len = 31'(b & 8'h01); hdr_left = 3'd5; end
          ph = lzf_pkg::PH_HEADER;
        end
      end
      lzf_pkg::PH_HEADER: begin
        exp_len = {exp_len[24:0], b[5:0]};
        hdr_left = hdr_left - 3'd1;
        if (hdr_left == 3'd0) ph = lzf_pkg::PH_CTRL;
      end
      lzf_pkg::PH_STORED: emit(b);
      lzf_pkg::PH_CTRL: begin
        if (b < 8'd32) begin
          if (64'(prod) + 64'(b) + 64'd1 > 64'(exp_len)) begin
            err = 1'b1; ph = lzf_pkg::PH_DRAIN;
          end else begin
            run_left = 9'(b) + 9'd1; ph = lzf_pkg::PH_LITERAL;
          end
        end else begin
          run_left = 9'(b[7:5]); off_hi = b[4:0];
          ph = (b[7:5] == 3'd7) ? lzf_pkg::PH_REFLEN : lzf_pkg::PH_REFOFF;
        end
      end
      lzf_pkg::PH_LITERAL: begin
        emit(b);
        run_left = run_left - 9'd1;
        if (run_left == 9'd0) ph = lzf_pkg::PH_CTRL;
      end
      lzf_pkg::PH_REFLEN: begin
        run_left = run_left + 9'(b);
        ph = lzf_pkg::PH_REFOFF;
      end
      lzf_pkg::PH_REFOFF: begin
        off = (32'(off_hi) << 8) + 32'(b) + 32'd1;
        total = 32'(run_left) + 32'd2;
        if (64'(prod) + 64'(total) > 64'(exp_len) || off > 32'(prod)) begin
          err = 1'b1; ph = lzf_pkg::PH_DRAIN;
        end else begin
          for (int i = 0; i < total; i++) emit(hist[(32'(prod) - off) % HDEPTH]);
          run_left = '0; ph = lzf_pkg::PH_CTRL;
        end
      end
      default: ;
    endcase
    n = step_bytes.size();
    for (int pos = 0; pos < n; pos += WB) begin
      cnt = (n - pos > WB) ? WB : n - pos;
      w = '0;
      for (int j = 0; j < cnt; j++) w.word[8*j +: 8] = step_bytes[pos + j];
      w.count = 4'(cnt);
      expected_words.push_back(w);
    end
    if (last) begin
      if (err) ok = 1'b0;
      else if (ph == lzf_pkg::PH_STORED) ok = 1'b1;
      else if (ph == lzf_pkg::PH_CTRL) ok = (prod == exp_len);
      else ok = 1'b0;
      w = '0; w.fend = 1'b1; w.fok = ok; w.dlen = prod;
      expected_words.push_back(w);
      clear_frame();
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // frame building
  logic [7:0] fb[$];

  task automatic put_header(input int unsigned len);
    if (len < 128) fb.push_back(8'(len));
    else if (len < 2048) begin
      fb.push_back(8'hc0 | 8'(len >> 6)); fb.push_back(8'h80 | 8'(len & 32'h3f));
    end else begin
      fb.push_back(8'he0 | 8'((len >> 12) & 32'h0f));
      fb.push_back(8'h80 | 8'((len >> 6) & 32'h3f)); fb.push_back(8'h80 | 8'(len & 32'h3f));
    end
  endtask

  task automatic send_frame();
    foreach (fb[i]) pending_bytes.push_back({fb[i], logic'(i == fb.size() - 1)});
    sent_total += fb.size();
    fb.delete();
  endtask

  // well formed LZF body, then header with exact length; optional breakage
  task automatic random_lzf_frame(input int ncmd, input int breakage);
    logic [7:0] body[$];
    int unsigned plen, off, rl;
    plen = 0;
    for (int c = 0; c < ncmd; c++) begin
      if (plen == 0 || $urandom_range(0, 2) == 0) begin
        rl = $urandom_range(1, 32);
        body.push_back(8'(rl - 1));
        for (int k = 0; k < rl; k++) body.push_back(8'($urandom));
        plen += rl;
      end else begin
        off = (plen > 8192) ? $urandom_range(1, 8192) : $urandom_range(1, plen);
        rl = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 264) : $urandom_range(3, 8);
        if (rl < 9) body.push_back(8'(((rl - 2) << 5) | ((off - 1) >> 8)));
        else begin
          body.push_back(8'he0 | 8'((off - 1) >> 8)); body.push_back(8'(rl - 9));
        end
        body.push_back(8'((off - 1) & 32'hff));
        plen += rl;
      end
    end
    case (breakage)
      1: put_header(plen + $urandom_range(1, 5));
      2: put_header(plen - 1);
      default: put_header(plen);
    endcase
    foreach (body[i]) fb.push_back(body[i]);
    if (breakage == 3) void'(fb.pop_back());
    if (breakage == 4) begin
      fb.push_back(8'h20 | 8'h1f); fb.push_back(8'hff);
    end
    send_frame();
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_byte_i, in_last_i);
        send_gap <= gap_len();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if ((!in_valid_i || !in_stall_o) && send_gap == 0 && !sender_pause
            && pending_bytes.size() > 0 && !(in_valid_i && !in_stall_o && send_gap != 0)) begin
          in_item_t it;
          it = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i <= it.data;
          in_last_i <= it.last;
        end else begin
          in_valid_i <= 1'b0;
          if (send_gap > 0 && !(in_valid_i && !in_stall_o)) send_gap <= send_gap - 1;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) report("unexpected transaction", out_word_o, 64'd0);
        else begin
          want = expected_words.pop_front();
          if (out_word_o !== want.word) report("out_word", out_word_o, want.word);
          if (out_count_o !== want.count)
            report("out_count", 64'(out_count_o), 64'(want.count));
          if (frame_end_o !== want.fend)
            report("frame_end", 64'(frame_end_o), 64'(want.fend));
          if (frame_ok_o !== want.fok)
            report("frame_ok", 64'(frame_ok_o), 64'(want.fok));
          if (decoded_length_o !== want.dlen)
            report("decoded_length", 64'(decoded_length_o), 64'(want.dlen));
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("lzf_frame_decompressor regression: fail");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    clear_frame();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: stored frame with extreme bytes
    fb = '{8'h00, 8'h00, 8'hff, 8'h5a}; send_frame();
    fb = '{8'h00}; send_frame();                 // empty stored frame
    fb = '{8'h00}; send_frame();
    fb = '{8'h00}; pending_bytes.push_back({8'h00, 1'b0});
    pending_bytes.push_back({8'h00, 1'b1}); fb.delete(); sent_total += 2;
    fb = '{8'h03, 8'h02, 8'h11, 8'h22, 8'h33}; send_frame();  // literal ok
    // overlapping reference: 1 literal, copy 7 at offset 1
    fb = '{8'h08, 8'h00, 8'ha5, 8'ha0, 8'h00}; send_frame();
    fb = '{8'h05}; send_frame();                 // header only, mismatch
    fb = '{8'hc1}; send_frame();                 // header cut short
    fb = '{8'hfd, 8'hbf}; send_frame();          // six-byte pattern, cut short
    fb = '{8'hf8, 8'h00, 8'h00, 8'h00, 8'h00}; send_frame(); // 5-byte header, len 0
    fb = '{8'h02, 8'h05, 8'h01}; send_frame();   // literal overrun
    fb = '{8'h09, 8'h00, 8'h01, 8'h20, 8'h05}; send_frame(); // ref before start
    fb = '{8'h06, 8'h02, 8'h01}; send_frame();   // stream cut in literal
    fb = '{8'h0a, 8'h00, 8'h07, 8'he0}; send_frame(); // cut before reflen
    // long reference 264 at offset 1
    fb = '{8'hc4, 8'h89, 8'h00, 8'h77, 8'he0, 8'hff, 8'h00}; send_frame();
    wait_drained();

    // long receiver hold-off while sender keeps going
    hold_off <= 400;
    fb.push_back(8'h00);
    for (int k = 0; k < 8; k++) fb.push_back(8'($urandom));
    send_frame();
    random_lzf_frame(1, 0);
    wait_drained();
    sender_pause <= 1'b0;

    // random frames
    while (sent_total < 95) begin
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 13) random_lzf_frame($urandom_range(1, 3), 0);
      else if (sel < 17) random_lzf_frame($urandom_range(1, 3), $urandom_range(1, 4));
      else if (sel < 19) begin
        int n;
        n = $urandom_range(0, 12);
        fb.push_back(8'h00);
        for (int k = 0; k < n; k++) fb.push_back(8'($urandom));
        send_frame();
      end else begin
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) fb.push_back(8'($urandom));
        send_frame();
      end
    end
    repeat (30) @(posedge clk_i);
    sender_pause <= 1'b1;
    @(posedge clk_i);
    while (expected_words.size() > 0 || in_valid_i) @(posedge clk_i);
    sender_pause <= 1'b0;
    wait_drained();
    random_lzf_frame(1, 0);
    wait_drained();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("lzf_frame_decompressor regression: pass");
    else
      $display("lzf_frame_decompressor regression: fail");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/lzf_pkg.sv
hw/rtl/lzf_front.sv
hw/rtl/lzf_cmd_fifo.sv
hw/rtl/lzf_back.sv
hw/rtl/lzf_frame_decompressor.sv
tb/tb.sv
